>>> rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and helpers for the JSON string unescaper
// Holds the request and result payload types, the parser mode and status
// codes, the character constants and the small decode functions.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // Parser mode.
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_STR  = 2'd1,
    MODE_ESC  = 2'd2,
    MODE_HEX  = 2'd3
  } mode_t;

  // Status codes carried by a status result.
  typedef enum logic [2:0] {
    ST_COMPLETE   = 3'd0,
    ST_EXPECTED   = 3'd1,
    ST_BAD_ESC    = 3'd2,
    ST_BAD_UNI    = 3'd3,
    ST_UNTERM_STR = 3'd4,
    ST_UNTERM_ESC = 3'd5
  } status_t;

  // Input request payload.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_t;

  // One result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    status_t    status;
    logic       last;
  } out_t;

  localparam int unsigned MAX_RESULTS = 3;

  // Results produced by one request, handed from decoder to output buffer.
  typedef struct packed {
    logic [1:0] count;
    out_t [MAX_RESULTS-1:0] item;
  } dec_t;

  // Characters with a role in the literal.
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_U      = 8'h75;

  // UTF-8 prefixes.
  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_CONT  = 8'h80;

  // Build a data result.
  function automatic out_t mk_data(input logic [7:0] b, input logic fin);
    out_t r;
    r.out_byte = b;
    r.is_data  = 1'b1;
    r.status   = ST_COMPLETE;
    r.last     = fin;
    return r;
  endfunction

  // Build a status result; it is always the final result of its request.
  function automatic out_t mk_status(input status_t st);
    out_t r;
    r.out_byte = 8'h00;
    r.is_data  = 1'b0;
    r.status   = st;
    r.last     = 1'b1;
    return r;
  endfunction

  // Hex digit value; bit 4 flags a valid digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      return {1'b1, d[3:0]};
    end
    if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      return {1'b1, d[3:0]};
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

  // Simple escape letter to byte; bit 8 flags a known letter.
  function automatic logic [8:0] simple_escape(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      CH_QUOTE:  r = {1'b1, CH_QUOTE};
      CH_BSLASH: r = {1'b1, CH_BSLASH};
      CH_SLASH:  r = {1'b1, CH_SLASH};
      8'h62:     r = {1'b1, 8'h08};
      8'h66:     r = {1'b1, 8'h0C};
      8'h6E:     r = {1'b1, 8'h0A};
      8'h72:     r = {1'b1, 8'h0D};
      8'h74:     r = {1'b1, 8'h09};
      default:   r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/jsu_decode.sv
// ----------------------------------------------------------------------------
// jsu_decode: parser state and per-byte decode
// Holds the parser mode, hex digit count and gathered code point, and turns
// one registered request into zero to three result items in a single pass.
// ----------------------------------------------------------------------------
module jsu_decode (
  input  logic           clk,
  input  logic           rst_n,
  input  jsu_pkg::in_t   item,
  input  logic           fire,
  output jsu_pkg::dec_t  dec
);

  jsu_pkg::mode_t mode_r, mode_nxt;
  logic [1:0]     hex_count_r, hex_count_nxt;
  logic [15:0]    code_point_r, code_point_nxt;

  logic [4:0]     hv;
  logic [8:0]     esc;
  logic [15:0]    cp_full;

  // State registers advance only when a request is consumed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= jsu_pkg::MODE_IDLE;
      hex_count_r  <= 2'd0;
      code_point_r <= 16'd0;
    end else if (fire) begin
      mode_r       <= mode_nxt;
      hex_count_r  <= hex_count_nxt;
      code_point_r <= code_point_nxt;
    end
  end

  assign hv      = jsu_pkg::hex_value(item.data_byte);
  assign esc     = jsu_pkg::simple_escape(item.data_byte);
  assign cp_full = {code_point_r[11:0], hv[3:0]};

  // Next state and results for the current byte.
  always_comb begin
    mode_nxt       = mode_r;
    hex_count_nxt  = hex_count_r;
    code_point_nxt = code_point_r;
    dec.count      = 2'd0;
    dec.item       = '0;

    if (item.end_of_input) begin
      dec.count      = 2'd1;
      mode_nxt       = jsu_pkg::MODE_IDLE;
      hex_count_nxt  = 2'd0;
      code_point_nxt = 16'd0;
      unique case (mode_r)
        jsu_pkg::MODE_IDLE: dec.item[0] = jsu_pkg::mk_status(jsu_pkg::ST_EXPECTED);
        jsu_pkg::MODE_ESC:  dec.item[0] = jsu_pkg::mk_status(jsu_pkg::ST_UNTERM_ESC);
        default:            dec.item[0] = jsu_pkg::mk_status(jsu_pkg::ST_UNTERM_STR);
      endcase
    end else begin
      unique case (mode_r)
        jsu_pkg::MODE_IDLE: begin
          if (item.data_byte == jsu_pkg::CH_QUOTE) begin
            mode_nxt = jsu_pkg::MODE_STR;
          end else begin
            dec.count   = 2'd1;
            dec.item[0] = jsu_pkg::mk_status(jsu_pkg::ST_EXPECTED);
          end
        end
        jsu_pkg::MODE_STR: begin
          if (item.data_byte == jsu_pkg::CH_QUOTE) begin
            dec.count   = 2'd1;
            dec.item[0] = jsu_pkg::mk_status(jsu_pkg::ST_COMPLETE);
            mode_nxt    = jsu_pkg::MODE_IDLE;
          end else if (item.data_byte == jsu_pkg::CH_BSLASH) begin
            mode_nxt = jsu_pkg::MODE_ESC;
          end else begin
            dec.count   = 2'd1;
            dec.item[0] = jsu_pkg::mk_data(item.data_byte, 1'b1);
          end
        end
        jsu_pkg::MODE_ESC: begin
          if (item.data_byte == jsu_pkg::CH_U) begin
            mode_nxt       = jsu_pkg::MODE_HEX;
            hex_count_nxt  = 2'd0;
            code_point_nxt = 16'd0;
          end else if (esc[8]) begin
            dec.count   = 2'd1;
            dec.item[0] = jsu_pkg::mk_data(esc[7:0], 1'b1);
            mode_nxt    = jsu_pkg::MODE_STR;
          end else begin
            dec.count   = 2'd1;
            dec.item[0] = jsu_pkg::mk_status(jsu_pkg::ST_BAD_ESC);
            mode_nxt    = jsu_pkg::MODE_IDLE;
          end
        end
        default: begin
          if (!hv[4]) begin
            dec.count      = 2'd1;
            dec.item[0]    = jsu_pkg::mk_status(jsu_pkg::ST_BAD_UNI);
            mode_nxt       = jsu_pkg::MODE_IDLE;
            hex_count_nxt  = 2'd0;
            code_point_nxt = 16'd0;
          end else if (hex_count_r == 2'd3) begin
            // Fourth digit: encode the code point as UTF-8.
            mode_nxt       = jsu_pkg::MODE_STR;
            hex_count_nxt  = 2'd0;
            code_point_nxt = 16'd0;
            if (cp_full[15:7] == 9'd0) begin
              dec.count   = 2'd1;
              dec.item[0] = jsu_pkg::mk_data({1'b0, cp_full[6:0]}, 1'b1);
            end else if (cp_full[15:11] == 5'd0) begin
              dec.count   = 2'd2;
              dec.item[0] = jsu_pkg::mk_data(jsu_pkg::UTF8_LEAD2 | {3'd0, cp_full[10:6]},
                                             1'b0);
              dec.item[1] = jsu_pkg::mk_data(jsu_pkg::UTF8_CONT | {2'd0, cp_full[5:0]},
                                             1'b1);
            end else begin
              dec.count   = 2'd3;
              dec.item[0] = jsu_pkg::mk_data(jsu_pkg::UTF8_LEAD3 | {4'd0, cp_full[15:12]},
                                             1'b0);
              dec.item[1] = jsu_pkg::mk_data(jsu_pkg::UTF8_CONT | {2'd0, cp_full[11:6]},
                                             1'b0);
              dec.item[2] = jsu_pkg::mk_data(jsu_pkg::UTF8_CONT | {2'd0, cp_full[5:0]},
                                             1'b1);
            end
          end else begin
            hex_count_nxt  = hex_count_r + 2'd1;
            code_point_nxt = cp_full;
          end
        end
      endcase
    end
  end

  // A nonzero digit count only exists while gathering hex digits.
  assert property (@(posedge clk) disable iff (!rst_n)
    hex_count_r != 2'd0 |-> mode_r == jsu_pkg::MODE_HEX)
    else $error("hex digit count set outside hex mode");

  // Any status result sends the parser back to idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    fire && dec.count != 2'd0 && !dec.item[0].is_data |=> mode_r == jsu_pkg::MODE_IDLE)
    else $error("parser not idle after a status result");

  // Only the end of a unicode escape yields more than one result.
  assert property (@(posedge clk) disable iff (!rst_n)
    mode_r != jsu_pkg::MODE_HEX |-> dec.count < 2'd2)
    else $error("multiple results outside a unicode escape");

endmodule

>>> rtl/jsu_out_buf.sv
// ----------------------------------------------------------------------------
// jsu_out_buf: result register and serializer
// Holds up to three results of one request and shows them on the result
// channel one per cycle while out_ready is high; reloads as the last one goes.
// ----------------------------------------------------------------------------
module jsu_out_buf (
  input  logic           clk,
  input  logic           rst_n,
  input  jsu_pkg::dec_t  dec,
  input  logic           fire,
  output logic           can_load,
  output logic           out_valid,
  input  logic           out_ready,
  output jsu_pkg::out_t  out_data
);

  jsu_pkg::out_t [jsu_pkg::MAX_RESULTS-1:0] res_r;
  logic [1:0] rem_r, rem_nxt;
  logic [1:0] pos_r, pos_nxt;
  logic       load;
  logic       pop;

  assign out_valid = rem_r != 2'd0;
  assign out_data  = res_r[pos_r];
  assign pop       = out_valid && out_ready;
  assign can_load  = rem_r == 2'd0 || (rem_r == 2'd1 && out_ready);
  assign load      = fire && dec.count != 2'd0;

  // Count and read position of the buffered results.
  always_comb begin
    rem_nxt = rem_r;
    pos_nxt = pos_r;
    if (load) begin
      rem_nxt = dec.count;
      pos_nxt = 2'd0;
    end else if (pop) begin
      rem_nxt = rem_r - 2'd1;
      pos_nxt = pos_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 2'd0;
      pos_r <= 2'd0;
    end else begin
      rem_r <= rem_nxt;
      pos_r <= pos_nxt;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= dec.item;
    end
  end

  // The final buffered result carries last.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && rem_r == 2'd1 |-> out_data.last)
    else $error("final result of a request without last");

  // Earlier results of a request never carry last.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && rem_r != 2'd1 |-> !out_data.last)
    else $error("last set before the final result");

  // A load never overwrites results still waiting.
  assert property (@(posedge clk) disable iff (!rst_n)
    load |-> rem_r == 2'd0 || (rem_r == 2'd1 && pop))
    else $error("result buffer overwritten");

endmodule

>>> rtl/json_string_unescape.sv
// ----------------------------------------------------------------------------
// json_string_unescape: JSON string literal decoder
// Takes the raw bytes of a JSON string literal and emits the decoded bytes
// and a closing status item.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests (in_valid/in_ready/in_data) carry one raw byte or an
//   end-of-input marker. Result requests (out_valid/out_ready/out_data)
//   carry a decoded byte or a status; last marks the final result of the
//   input request that caused it. Opening quotes, backslashes and the first
//   digits of a \u escape produce no result.
//   Path: a request is captured in the input register, decoded combinationally
//   and loaded into the result register once that register can take its
//   results; its first result is then shown on out_valid.
//   Throughput: one request per cycle while each yields at most one result
//   and out_ready stays high. A \u escape that encodes to two or three UTF-8
//   bytes holds the input until the single result port has drained the
//   result register, one byte per cycle while out_ready is high.
//   Reset (rst_n low, synchronous) empties both registers and puts the
//   parser in idle, awaiting an opening quote.
//   When the receiver stalls, results hold steady; the input register then
//   fills and in_ready drops until the result register can reload.
// ----------------------------------------------------------------------------
module json_string_unescape (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  jsu_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output jsu_pkg::out_t  out_data
);

  jsu_pkg::in_t  s1_r;
  logic          s1_valid_r, s1_valid_nxt;
  logic          s1_fire;
  logic          can_load;
  jsu_pkg::dec_t dec;

  // Input register: consumed when the result register can take its results.
  assign s1_fire  = s1_valid_r && can_load;
  assign in_ready = !s1_valid_r || s1_fire;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_r <= in_data;
    end
  end

  jsu_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (s1_r),
    .fire  (s1_fire),
    .dec   (dec)
  );

  jsu_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .dec       (dec),
    .fire      (s1_fire),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the JSON string unescaper
// A short table of directed requests walks the idle, string, escape and hex
// states with their error exits. Random literals follow, most of them well
// formed, some broken or preceded by noise. Every accepted request is run
// through a local decoder, and each result is checked field by field against
// the oldest pending expectation. Both handshakes idle in random bursts. The
// receiver also holds off once for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module testbench;
  import jsu_pkg::*;

  // One row of stimulus. When typed is set, want is the result to check for
  // instead of what the local decoder works out.
  typedef struct {
    in_t  req;
    bit   typed;
    out_t want;
  } stim_row_t;

  localparam out_t NO_RESULT = '0;
  localparam int   N_DIRECTED = 29;
  localparam int   N_RANDOM = 200;
  localparam int   TAIL_ITEMS = 40;

  // Escape letters and hex digits used to build literals.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_BAD_Q = 8'h71;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  json_string_unescape dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  stim_row_t   stim_q[$];
  stim_row_t   directed_tab [N_DIRECTED];
  out_t        due_results[$];
  out_t        step_results[$];
  int unsigned accepted_reqs = 0;
  int unsigned error_count = 0;
  logic        tail_phase = 1'b0;

  // Local copy of the decoder state.
  mode_t       dec_mode = MODE_IDLE;
  logic [1:0]  dec_digits = 2'd0;
  logic [15:0] dec_code = 16'h0000;

  function automatic out_t data_res(input logic [7:0] b, input logic fin);
    out_t r;
    r.out_byte = b;
    r.is_data  = 1'b1;
    r.status   = ST_COMPLETE;
    r.last     = fin;
    return r;
  endfunction

  function automatic out_t status_res(input status_t st);
    out_t r;
    r = '0;
    r.status = st;
    r.last   = 1'b1;
    return r;
  endfunction

  function automatic in_t byte_req(input logic [7:0] b);
    in_t r;
    r.data_byte    = b;
    r.end_of_input = 1'b0;
    return r;
  endfunction

  function automatic in_t eoi_req(input logic [7:0] junk);
    in_t r;
    r.data_byte    = junk;
    r.end_of_input = 1'b1;
    return r;
  endfunction

  // Value of a hex digit in either case, or -1.
  function automatic int hex_val(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_ZERO + 8'd9) return int'(c - CH_ZERO);
    if (c >= CH_LC_A && c <= CH_LC_A + 8'd5) return int'(c - CH_LC_A) + 10;
    if (c >= CH_UC_A && c <= CH_UC_A + 8'd5) return int'(c - CH_UC_A) + 10;
    return -1;
  endfunction

  // Byte produced by a one-letter escape, or -1 for an unknown letter.
  function automatic int unesc(input logic [7:0] c);
    case (c)
      CH_QUOTE:  return int'(CH_QUOTE);
      CH_BSLASH: return int'(CH_BSLASH);
      CH_SLASH:  return int'(CH_SLASH);
      8'h62:     return 8'h08;   // b
      8'h66:     return 8'h0C;   // f
      8'h6E:     return 8'h0A;   // n
      8'h72:     return 8'h0D;   // r
      8'h74:     return 8'h09;   // t
      default:   return -1;
    endcase
  endfunction

  // A status result ends the literal and drops the decoder back to idle.
  function automatic void close_with(input status_t st);
    step_results.push_back(status_res(st));
    dec_mode   = MODE_IDLE;
    dec_digits = 2'd0;
    dec_code   = 16'h0000;
  endfunction

  // UTF-8 encoding of one 16-bit code point.
  function automatic void push_utf8(input logic [15:0] cp);
    if (cp < 16'h0080) begin
      step_results.push_back(data_res(cp[7:0], 1'b1));
    end else if (cp < 16'h0800) begin
      step_results.push_back(data_res({3'b110, cp[10:6]}, 1'b0));
      step_results.push_back(data_res({2'b10, cp[5:0]}, 1'b1));
    end else begin
      step_results.push_back(data_res({4'b1110, cp[15:12]}, 1'b0));
      step_results.push_back(data_res({2'b10, cp[11:6]}, 1'b0));
      step_results.push_back(data_res({2'b10, cp[5:0]}, 1'b1));
    end
  endfunction

  // Decode one request into step_results and advance the local state.
  function automatic void unescape_step(input in_t req);
    logic [7:0] c;
    int         v;
    c = req.data_byte;
    step_results.delete();
    if (req.end_of_input) begin
      case (dec_mode)
        MODE_IDLE: close_with(ST_EXPECTED);
        MODE_ESC:  close_with(ST_UNTERM_ESC);
        default:   close_with(ST_UNTERM_STR);
      endcase
      return;
    end
    case (dec_mode)
      MODE_IDLE: begin
        if (c == CH_QUOTE) dec_mode = MODE_STR;
        else close_with(ST_EXPECTED);
      end
      MODE_STR: begin
        if (c == CH_QUOTE) close_with(ST_COMPLETE);
        else if (c == CH_BSLASH) dec_mode = MODE_ESC;
        else step_results.push_back(data_res(c, 1'b1));
      end
      MODE_ESC: begin
        if (c == CH_U) begin
          dec_mode   = MODE_HEX;
          dec_digits = 2'd0;
          dec_code   = 16'h0000;
        end else begin
          v = unesc(c);
          if (v < 0) begin
            close_with(ST_BAD_ESC);
          end else begin
            dec_mode = MODE_STR;
            step_results.push_back(data_res(v[7:0], 1'b1));
          end
        end
      end
      default: begin
        v = hex_val(c);
        if (v < 0) begin
          close_with(ST_BAD_UNI);
        end else begin
          dec_code = {dec_code[11:0], v[3:0]};
          if (dec_digits == 2'd3) begin
            dec_mode   = MODE_STR;
            dec_digits = 2'd0;
            push_utf8(dec_code);
            dec_code   = 16'h0000;
          end else begin
            dec_digits = dec_digits + 2'd1;
          end
        end
      end
    endcase
  endfunction

  // Random stimulus helpers.
  task automatic add_req(input in_t req);
    stim_row_t row;
    row.req   = req;
    row.typed = 1'b0;
    row.want  = NO_RESULT;
    stim_q.push_back(row);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return CH_ZERO + 8'(n);
    if ($urandom_range(0, 1) == 0) return CH_UC_A + 8'(n - 4'd10);
    return CH_LC_A + 8'(n - 4'd10);
  endfunction

  task automatic add_plain();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == CH_QUOTE || b == CH_BSLASH) b = 8'($urandom_range(0, 255));
    add_req(byte_req(b));
  endtask

  task automatic add_simple_esc();
    logic [7:0] letters [8];
    letters = '{CH_QUOTE, CH_BSLASH, CH_SLASH, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74};
    add_req(byte_req(CH_BSLASH));
    add_req(byte_req(letters[$urandom_range(0, 7)]));
  endtask

  task automatic add_unicode_esc();
    logic [15:0] cp;
    logic [15:0] edges [6];
    edges = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF};
    case ($urandom_range(0, 4))
      0:       cp = 16'($urandom_range(16'h0000, 16'h007F));
      1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
      2:       cp = 16'($urandom_range(16'h0800, 16'hFFFF));
      3:       cp = edges[$urandom_range(0, 5)];
      default: cp = 16'($urandom);
    endcase
    add_req(byte_req(CH_BSLASH));
    add_req(byte_req(CH_U));
    for (int i = 3; i >= 0; i--) add_req(byte_req(hex_char(cp[4*i +: 4])));
  endtask

  task automatic add_element();
    case ($urandom_range(0, 5))
      0, 1, 2: add_plain();
      3:       add_simple_esc();
      default: add_unicode_esc();
    endcase
  endtask

  // One literal: mostly well formed, else broken at a random point or noise.
  task automatic add_literal();
    logic [7:0] b;
    int         kind;
    int         n;
    kind = $urandom_range(0, 99);
    if (kind >= 90) begin
      // Noise or end of input before any opening quote.
      if ($urandom_range(0, 2) == 0) begin
        add_req(eoi_req(8'($urandom_range(0, 255))));
      end else begin
        b = 8'($urandom_range(0, 255));
        while (b == CH_QUOTE) b = 8'($urandom_range(0, 255));
        add_req(byte_req(b));
      end
      return;
    end
    add_req(byte_req(CH_QUOTE));
    n = (kind < 70) ? $urandom_range(0, 6) : $urandom_range(0, 3);
    for (int i = 0; i < n; i++) add_element();
    if (kind < 70) begin
      add_req(byte_req(CH_QUOTE));
      return;
    end
    case ($urandom_range(0, 4))
      0: add_req(eoi_req(8'($urandom_range(0, 255))));
      1: begin
        add_req(byte_req(CH_BSLASH));
        add_req(eoi_req(8'($urandom_range(0, 255))));
      end
      2: begin
        b = 8'($urandom_range(0, 255));
        while (b == CH_U || unesc(b) >= 0) b = 8'($urandom_range(0, 255));
        add_req(byte_req(CH_BSLASH));
        add_req(byte_req(b));
      end
      default: begin
        add_req(byte_req(CH_BSLASH));
        add_req(byte_req(CH_U));
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) add_req(byte_req(hex_char(4'($urandom_range(0, 15)))));
        if ($urandom_range(0, 3) == 0) begin
          add_req(eoi_req(8'($urandom_range(0, 255))));
        end else begin
          b = 8'($urandom_range(0, 255));
          while (hex_val(b) >= 0) b = 8'($urandom_range(0, 255));
          add_req(byte_req(b));
        end
      end
    endcase
  endtask

  // Build the stimulus, then release reset.
  initial begin
    directed_tab = '{
      '{eoi_req(8'hFF),       1'b1, status_res(ST_EXPECTED)},
      '{byte_req(8'h00),      1'b1, status_res(ST_EXPECTED)},
      '{byte_req(CH_QUOTE),   1'b0, NO_RESULT},
      '{byte_req(8'hFF),      1'b1, data_res(8'hFF, 1'b1)},
      // NUL code point comes out as a single zero byte.
      '{byte_req(CH_BSLASH),  1'b0, NO_RESULT},
      '{byte_req(CH_U),       1'b0, NO_RESULT},
      '{byte_req(CH_ZERO),    1'b0, NO_RESULT},
      '{byte_req(CH_ZERO),    1'b0, NO_RESULT},
      '{byte_req(CH_ZERO),    1'b0, NO_RESULT},
      '{byte_req(CH_ZERO),    1'b1, data_res(8'h00, 1'b1)},
      // Largest code point, mixed-case digits, three UTF-8 bytes.
      '{byte_req(CH_BSLASH),  1'b0, NO_RESULT},
      '{byte_req(CH_U),       1'b0, NO_RESULT},
      '{byte_req(8'h46),      1'b0, NO_RESULT},
      '{byte_req(8'h66),      1'b0, NO_RESULT},
      '{byte_req(8'h46),      1'b0, NO_RESULT},
      '{byte_req(8'h66),      1'b0, NO_RESULT},
      '{byte_req(CH_QUOTE),   1'b1, status_res(ST_COMPLETE)},
      // Unknown escape letter.
      '{byte_req(CH_QUOTE),   1'b0, NO_RESULT},
      '{byte_req(CH_BSLASH),  1'b0, NO_RESULT},
      '{byte_req(CH_BAD_Q),   1'b1, status_res(ST_BAD_ESC)},
      // End of input right after a backslash.
      '{byte_req(CH_QUOTE),   1'b0, NO_RESULT},
      '{byte_req(CH_BSLASH),  1'b0, NO_RESULT},
      '{eoi_req(8'h00),       1'b1, status_res(ST_UNTERM_ESC)},
      // End of input inside the string.
      '{byte_req(CH_QUOTE),   1'b0, NO_RESULT},
      '{eoi_req(8'h5A),       1'b1, status_res(ST_UNTERM_STR)},
      // A quote where a hex digit belongs.
      '{byte_req(CH_QUOTE),   1'b0, NO_RESULT},
      '{byte_req(CH_BSLASH),  1'b0, NO_RESULT},
      '{byte_req(CH_U),       1'b0, NO_RESULT},
      '{byte_req(CH_QUOTE),   1'b1, status_res(ST_BAD_UNI)}
    };
    foreach (directed_tab[i]) stim_q.push_back(directed_tab[i]);
    while (stim_q.size() < N_DIRECTED + N_RANDOM) add_literal();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Request driver with random idle bursts, none in the tail.
  int unsigned send_idx = 0;
  int unsigned send_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (send_idx < stim_q.size()) begin
          in_valid <= 1'b1;
          in_data  <= stim_q[send_idx].req;
          send_idx++;
          if (send_idx + TAIL_ITEMS >= stim_q.size()) tail_phase <= 1'b1;
          else if ($urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 18);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: random stall bursts plus one long hold-off.
  int unsigned rx_cycle = 0;
  int unsigned rx_stall = 0;
  int unsigned rx_hold = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      rx_cycle++;
      if (rx_cycle == 200) rx_hold = 80;
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_ready <= 1'b0;
      end else if (!tail_phase && $urandom_range(0, 6) == 0) begin
        rx_stall = $urandom_range(0, 17);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Predict on each accepted request, check each accepted result.
  always @(posedge clk) begin : monitor
    stim_row_t row;
    out_t      want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        row = stim_q[accepted_reqs];
        accepted_reqs++;
        unescape_step(row.req);
        if (row.typed) due_results.push_back(row.want);
        else foreach (step_results[i]) due_results.push_back(step_results[i]);
      end
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $error("unexpected result %h with nothing pending", out_data);
          error_count++;
        end else begin
          want = due_results.pop_front();
          if (out_data.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, out_data.out_byte);
            error_count++;
          end
          if (out_data.is_data !== want.is_data) begin
            $error("is_data: expected %b, got %b", want.is_data, out_data.is_data);
            error_count++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            error_count++;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %b, got %b", want.last, out_data.last);
            error_count++;
          end
        end
      end
    end
  end

  // Wait for every request to be taken and every result to arrive.
  initial begin
    @(posedge rst_n);
    while (accepted_reqs < stim_q.size() || due_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("testbench failed");
    $finish;
  end

endmodule
